// File: rtl/assert_macros.svh
// Assertion helpers; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ebb_pkg.sv
`default_nettype none
package ebb_pkg;
	localparam int PIX_W           = 24;
	localparam int CH_W            = 8;
	localparam int NUM_CH          = 3;
	localparam int PEND_W          = 11;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;
	localparam int CFG_WIDTH_BITS  = 11;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int CFG_DATA_W      = 13;
	localparam int DIV_STEPS       = 8;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic accept;
		logic read;
		logic shift;
		logic sum;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		logic emit;
	} stat_t;
endpackage
`default_nettype wire

// File: rtl/edge_aware_box_blur_3x3_top.sv
// 3x3 box blur on an RGB raster stream, averaging only the neighbours that
// lie inside the image (9 inside, 6 on an edge, 4 at a corner), each channel
// rounded half up. Each request on the slave side is either a pixel
// (tuser = 0) or a flush tick (tuser = 1). Results trail the input by
// width+1 pixels; after the last pixel of a frame send flush ticks to drain
// the outstanding width+1 results, before the first pixel of the next frame.
// m_tlast marks the last result of a frame. One request is handled at a
// time: accept, row-store read, then window shift and row-store write; a
// request that yields a result goes on through the sum and the 8-step
// restoring divider before m_tvalid rises, then waits on m_tready. Write
// image_width and image_height only while the block is idle. Row-store
// entries are never cleared; those of an earlier frame, read in the first
// row, are masked out at the edge, but a one-row frame does use them.
`default_nettype none
`include "assert_macros.svh"
module edge_aware_box_blur_3x3_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  wire logic        s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic             m_tlast,   // frame_end
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [ebb_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic [ebb_pkg::CFG_WIDTH_BITS-1:0]  width_q;
	logic [ebb_pkg::CFG_HEIGHT_BITS-1:0] height_q;
	ebb_pkg::cmd_t  cmd;
	ebb_pkg::stat_t stat;

	// configuration registers; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ebb_pkg::CFG_WIDTH_BITS'(1024);
			height_q <= ebb_pkg::CFG_HEIGHT_BITS'(768);
		end else if (cfg_valid) begin
			case (cfg_index)
				ebb_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_data[ebb_pkg::CFG_WIDTH_BITS-1:0];
				ebb_pkg::CFG_IDX_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: accept, read, shift, sum, divide, present
	ebb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// counters, row stores, window, sums and divider
	ebb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_mode      (s_tuser),
		.in_pix       (s_tdata),
		.image_width  (width_q),
		.image_height (height_q),
		.out_pix      (m_tdata),
		.out_last     (m_tlast)
	);

	// a result on offer means no request can be taken
	`ASSERT_IMPLY(a_excl, clk, arst_n, m_tvalid, !s_tready)
	// an accepted request closes the slave side for the next cycle
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a stalled result is held
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire

// File: rtl/ebb_ctrl.sv
`default_nettype none
module ebb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire ebb_pkg::stat_t stat,
	output ebb_pkg::cmd_t       cmd
);
	typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_SUM, S_DIV, S_OUT} state_t;

	localparam int CNT_W = $clog2(ebb_pkg::DIV_STEPS);

	state_t           state_q;
	logic             rdy_q;
	logic             vld_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
			vld_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_READ;
						rdy_q   <= 1'b0;
					end
				end
				S_READ: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (stat.emit) begin
						state_q <= S_SUM;
					end else begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				S_SUM: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ebb_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
						vld_q   <= 1'b1;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
						vld_q   <= 1'b0;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					vld_q   <= 1'b0;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready     = rdy_q;
	assign m_tvalid     = vld_q;
	assign cmd.accept   = rdy_q & s_tvalid;
	assign cmd.read     = (state_q == S_READ);
	assign cmd.shift    = (state_q == S_SHIFT);
	assign cmd.sum      = (state_q == S_SUM);
	assign cmd.div_step = (state_q == S_DIV);
endmodule
`default_nettype wire

// File: rtl/ebb_datapath.sv
`default_nettype none
module ebb_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ebb_pkg::cmd_t                        cmd,
	output ebb_pkg::stat_t                            stat,
	input  wire logic                                 in_mode,
	input  wire logic [ebb_pkg::PIX_W-1:0]            in_pix,
	input  wire logic [ebb_pkg::CFG_WIDTH_BITS-1:0]   image_width,
	input  wire logic [ebb_pkg::CFG_HEIGHT_BITS-1:0]  image_height,
	output logic      [ebb_pkg::PIX_W-1:0]            out_pix,
	output logic                                      out_last
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int HEW = $clog2(MAX_HEIGHT + 1);
	localparam int KA  = (HEW > WEW) ? HEW : WEW;
	localparam int K   = ((KA > ebb_pkg::CFG_HEIGHT_BITS) ? KA : ebb_pkg::CFG_HEIGHT_BITS) + 1;
	localparam int PW  = ebb_pkg::PIX_W;
	localparam int CH  = ebb_pkg::CH_W;
	localparam int SW  = CH + 4;
	localparam int NW  = SW + 1;

	logic [CW-1:0]              ic_q, oc_q, ocl_q, addr_q;
	logic [RW-1:0]              ir_q, or_q, orl_q;
	logic [ebb_pkg::PEND_W-1:0] pend_q;
	logic                       emit_q, mode_q;
	logic [PW-1:0]              pix_q;

	logic [K-1:0] w_k, h_k, wc_k, hc_k;
	logic [K-1:0] c1, r1, c2, r2, oc_b, or_b, oc_n, or_n, v_k, ocs, ors;
	logic         fs, emit_pix, emit_fl, emit_n;
	logic [ebb_pkg::PEND_W-1:0] p0, p1, pend_n;

	always_comb begin
		wc_k = K'(image_width);
		hc_k = K'(image_height);
		w_k  = (wc_k == '0) ? K'(1) : ((wc_k > K'(MAX_WIDTH)) ? K'(MAX_WIDTH) : wc_k);
		h_k  = (hc_k == '0) ? K'(1) : ((hc_k > K'(MAX_HEIGHT)) ? K'(MAX_HEIGHT) : hc_k);

		c1 = K'(ic_q);
		r1 = K'(ir_q);
		if (c1 >= w_k) begin
			c1 = '0;
			r1 = r1 + 1'b1;
		end
		if (r1 >= h_k) r1 = '0;
		fs = (c1 == '0) && (r1 == '0);
		c2 = c1 + 1'b1;
		r2 = r1;
		if (c2 >= w_k) begin
			c2 = '0;
			r2 = r1 + 1'b1;
			if (r2 >= h_k) r2 = '0;
		end

		p0       = fs ? '0 : pend_q;
		p1       = (p0 < ebb_pkg::PEND_MAX) ? p0 + 1'b1 : p0;
		emit_pix = K'(p1) > (w_k + 1'b1);
		emit_fl  = (pend_q != '0) && (ic_q == '0) && (ir_q == '0);

		v_k = K'(oc_q) + 1'b1;
		if (v_k >= w_k) v_k = '0;

		// the output position the result belongs to
		ocs = (in_mode == ebb_pkg::MODE_PIXEL && fs) ? '0 : K'(oc_q);
		ors = (in_mode == ebb_pkg::MODE_PIXEL && fs) ? '0 : K'(or_q);
		oc_b = ocs;
		or_b = ors;
		emit_n = (in_mode == ebb_pkg::MODE_PIXEL) ? emit_pix : emit_fl;
		oc_n = oc_b;
		or_n = or_b;
		if (emit_n) begin
			oc_n = oc_b + 1'b1;
			if (oc_n >= w_k) begin
				oc_n = '0;
				or_n = or_b + 1'b1;
				if (or_n >= h_k) or_n = '0;
			end
		end
		if (in_mode == ebb_pkg::MODE_PIXEL) begin
			pend_n = emit_pix ? p1 - 1'b1 : p1;
		end else begin
			pend_n = emit_fl ? pend_q - 1'b1 : pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q   <= '0;
			ir_q   <= '0;
			oc_q   <= '0;
			or_q   <= '0;
			pend_q <= '0;
			emit_q <= 1'b0;
		end else if (cmd.accept) begin
			if (in_mode == ebb_pkg::MODE_PIXEL) begin
				ic_q <= c2[CW-1:0];
				ir_q <= r2[RW-1:0];
			end
			oc_q   <= oc_n[CW-1:0];
			or_q   <= or_n[RW-1:0];
			pend_q <= pend_n;
			emit_q <= emit_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= in_mode;
			pix_q  <= (in_mode == ebb_pkg::MODE_PIXEL) ? in_pix : '0;
			addr_q <= (in_mode == ebb_pkg::MODE_PIXEL) ? c1[CW-1:0] : v_k[CW-1:0];
			ocl_q  <= oc_b[CW-1:0];
			orl_q  <= or_b[RW-1:0];
		end
	end

	assign stat.emit = emit_q;

	// row stores
	logic [PW-1:0] older_mem  [MAX_WIDTH];
	logic [PW-1:0] recent_mem [MAX_WIDTH];
	logic [PW-1:0] rd_old_q, rd_rec_q;

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_old_q <= older_mem[addr_q];
			rd_rec_q <= recent_mem[addr_q];
		end
		if (cmd.shift && mode_q == ebb_pkg::MODE_PIXEL) begin
			older_mem[addr_q]  <= rd_rec_q;
			recent_mem[addr_q] <= pix_q;
		end
	end

	// window, index column*3 + row; a flush tick with nothing to give leaves it alone
	logic [PW-1:0] win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else if (cmd.shift && (mode_q == ebb_pkg::MODE_PIXEL || emit_q)) begin
			for (int k = 0; k < 6; k++) win_q[k] <= win_q[k+3];
			win_q[6] <= rd_old_q;
			win_q[7] <= rd_rec_q;
			win_q[8] <= pix_q;
		end
	end

	// masked sums
	logic [2:0]    col_ok, row_ok;
	logic [3:0]    cnt;
	logic [SW-1:0] sums [ebb_pkg::NUM_CH];
	logic [NW-1:0] num  [ebb_pkg::NUM_CH];

	always_comb begin
		col_ok[0] = ocl_q != '0;
		col_ok[1] = 1'b1;
		col_ok[2] = (K'(ocl_q) + 1'b1) < w_k;
		row_ok[0] = orl_q != '0;
		row_ok[1] = 1'b1;
		row_ok[2] = (K'(orl_q) + 1'b1) < h_k;
		cnt = '0;
		for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) sums[ch] = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (col_ok[c] && row_ok[r]) begin
					cnt = cnt + 1'b1;
					for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++)
						sums[ch] = sums[ch] + SW'(win_q[c*3+r][ch*CH +: CH]);
				end
			end
		end
		for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++)
			num[ch] = {sums[ch], 1'b0} + NW'(cnt);
	end

	// restoring divide, one quotient bit per step
	logic [4:0]    den_q;
	logic [4:0]    rem_q [ebb_pkg::NUM_CH];
	logic [CH-1:0] nlo_q [ebb_pkg::NUM_CH];
	logic [CH-1:0] quo_q [ebb_pkg::NUM_CH];
	logic          fe_q;
	logic [5:0]    trial [ebb_pkg::NUM_CH];
	logic          ge    [ebb_pkg::NUM_CH];

	always_comb begin
		for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
			trial[ch] = {rem_q[ch], nlo_q[ch][CH-1]};
			ge[ch]    = trial[ch] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			den_q <= {cnt, 1'b0};
			fe_q  <= ((K'(orl_q) + 1'b1) >= h_k) && ((K'(ocl_q) + 1'b1) >= w_k);
			for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
				rem_q[ch] <= num[ch][NW-1:CH];
				nlo_q[ch] <= num[ch][CH-1:0];
			end
		end else if (cmd.div_step) begin
			for (int ch = 0; ch < ebb_pkg::NUM_CH; ch++) begin
				rem_q[ch] <= ge[ch] ? 5'(trial[ch] - {1'b0, den_q}) : trial[ch][4:0];
				quo_q[ch] <= {quo_q[ch][CH-2:0], ge[ch]};
				nlo_q[ch] <= {nlo_q[ch][CH-2:0], 1'b0};
			end
		end
	end

	assign out_pix  = {quo_q[2], quo_q[1], quo_q[0]};
	assign out_last = fe_q;
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} blur_t;

	localparam int MAXW = 1024;
	localparam int MAXH = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [ebb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	edge_aware_box_blur_3x3_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock: 10 units period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// blur predictor state
	logic [10:0] reg_width;
	logic [12:0] reg_height;
	rgb_t older_row[MAXW];
	rgb_t recent_row[MAXW];
	rgb_t win[9];
	int unsigned in_col, in_row, out_col, out_row, pending;
	blur_t blurred_q[$];

	int errors = 0;
	int pixels_sent = 0;
	int flushes_sent = 0;
	int results_seen = 0;
	int unsigned widest = 0;   // widest row written to the row stores so far
	bit quiet = 0;         // no idling on either side when set
	bit hold_req = 0;      // ask the receiver for one long hold-off

	function automatic int unsigned eff_w();
		if (reg_width == 0) return 1;
		if (reg_width > MAXW) return MAXW;
		return reg_width;
	endfunction

	function automatic int unsigned eff_h();
		if (reg_height == 0) return 1;
		if (reg_height > MAXH) return MAXH;
		return reg_height;
	endfunction

	function automatic void shift_window(rgb_t top, rgb_t mid, rgb_t bot);
		for (int k = 0; k < 6; k++) win[k] = win[k+3];
		win[6] = top;
		win[7] = mid;
		win[8] = bot;
	endfunction

	// average the in-image neighbours and advance the output position
	function automatic void emit_blurred(int unsigned w, int unsigned h);
		bit col_ok[3];
		bit row_ok[3];
		int unsigned sr, sg, sb, cnt;
		blur_t o;
		sr = 0; sg = 0; sb = 0; cnt = 0;
		col_ok[0] = out_col > 0; col_ok[1] = 1; col_ok[2] = out_col + 1 < w;
		row_ok[0] = out_row > 0; row_ok[1] = 1; row_ok[2] = out_row + 1 < h;
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				if (col_ok[c] && row_ok[r]) begin
					sr += win[c*3+r].r;
					sg += win[c*3+r].g;
					sb += win[c*3+r].b;
					cnt++;
				end
		o.r = 8'((2*sr + cnt) / (2*cnt));
		o.g = 8'((2*sg + cnt) / (2*cnt));
		o.b = 8'((2*sb + cnt) / (2*cnt));
		o.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		blurred_q.push_back(o);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		if (pending > 0) pending--;
	endfunction

	function automatic void predict_blur(logic mode, rgb_t p);
		int unsigned w, h, c, v;
		rgb_t zero;
		w = eff_w();
		h = eff_h();
		zero = '0;
		if (mode == ebb_pkg::MODE_PIXEL) begin
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (in_row >= h) in_row = 0;
			if (in_col == 0 && in_row == 0) begin
				pending = 0;
				out_col = 0;
				out_row = 0;
			end
			c = in_col;
			shift_window(older_row[c], recent_row[c], p);
			older_row[c] = recent_row[c];
			recent_row[c] = p;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) in_row = 0;
			end
			if (pending < 2047) pending++;
			if (pending > w + 1) emit_blurred(w, h);
		end else if (pending > 0 && in_col == 0 && in_row == 0) begin
			v = out_col + 1;
			if (v >= w) v = 0;
			shift_window(older_row[v], recent_row[v], zero);
			emit_blurred(w, h);
		end
	endfunction

	// send one request on the slave side; idle bursts come before it at random
	task automatic send_item(logic mode, rgb_t p);
		int gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {p.b, p.g, p.r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_blur(mode, p);
		if (mode == ebb_pkg::MODE_PIXEL) pixels_sent++;
		else flushes_sent++;
	endtask

	task automatic release_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected result, then let a request with no result finish
	task automatic drain();
		release_input();
		while (blurred_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ebb_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == ebb_pkg::CFG_IDX_WIDTH) reg_width = 11'(value);
		else reg_height = 13'(value);
		@(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		drain();
		write_reg(ebb_pkg::CFG_IDX_WIDTH, w);
		write_reg(ebb_pkg::CFG_IDX_HEIGHT, h);
	endtask

	function automatic rgb_t pick_pixel(int unsigned style);
		rgb_t p;
		case (style)
			0: p = '0;
			1: p = '1;
			2: p = ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h000000;
			default: p = rgb_t'(24'($urandom()));
		endcase
		return p;
	endfunction

	// one whole frame plus its drain; stray flush ticks mid-frame are no-ops,
	// and skip_drain leaves results for the next frame start to discard
	task automatic run_frame(int unsigned style, bit strays, bit skip_drain);
		int unsigned n, w;
		rgb_t zero;
		zero = '0;
		w = eff_w();
		n = w * eff_h();
		for (int i = 0; i < n; i++) begin
			if (strays && i > 0 && $urandom_range(0, 7) == 0)
				send_item(ebb_pkg::MODE_FLUSH, pick_pixel(3));
			send_item(ebb_pkg::MODE_PIXEL, pick_pixel(style));
		end
		if (!skip_drain)
			for (int i = 0; i < w + 1; i++) send_item(ebb_pkg::MODE_FLUSH, pick_pixel(3));
		if (strays)
			send_item(ebb_pkg::MODE_FLUSH, zero);
		if (w > widest) widest = w;
	endtask

	task automatic test_directed();
		set_frame(2, 2);
		run_frame(2, 0, 0);
		set_frame(1, 1);
		run_frame(1, 0, 0);
		set_frame(0, 0);      // zero registers act as one
		run_frame(0, 1, 0);
		set_frame(3, 3);
		run_frame(1, 0, 0);
		run_frame(3, 0, 0);
		set_frame(4, 2);
		run_frame(3, 1, 0);
	endtask

	task automatic test_random_frames(int target);
		int unsigned w, h;
		while (pixels_sent + flushes_sent < target) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			if ($urandom_range(0, 9) == 0) w = $urandom_range(10, 40);
			// a one-row frame centres its first result on the last column
			// stored by an earlier frame, so keep it within stored columns
			if (h == 1 && w > widest) h = 2;
			set_frame(w, h);
			repeat ($urandom_range(1, 2))
				run_frame($urandom_range(0, 5), $urandom_range(0, 3) == 0,
					$urandom_range(0, 7) == 0);
		end
	endtask

	task automatic test_backpressure();
		set_frame(16, 4);
		hold_req = 1;
		run_frame(3, 0, 0);
		run_frame(3, 0, 0);
	endtask

	task automatic test_no_idle();
		quiet = 1;
		set_frame(5, 4);
		run_frame(3, 0, 0);
		set_frame(7, 3);
		run_frame(3, 1, 0);
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				for (n = 0; n < 400; n++) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		blur_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (blurred_q.size() == 0) begin
				$error("result with no expectation: %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				e = blurred_q.pop_front();
				if (m_tdata[7:0] !== e.r) begin
					$error("red_out expected %0d got %0d", e.r, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== e.g) begin
					$error("green_out expected %0d got %0d", e.g, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== e.b) begin
					$error("blue_out expected %0d got %0d", e.b, m_tdata[23:16]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("frame_end expected %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		reg_width = 1024;
		reg_height = 768;
		for (int i = 0; i < MAXW; i++) begin
			older_row[i] = '0;
			recent_row[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;
		in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_frames(pixels_sent + flushes_sent + 320);
		test_no_idle();
		drain();
		if (blurred_q.size() != 0) begin
			$error("%0d expected results never arrived", blurred_q.size());
			errors++;
		end
		$display("covered %0d pixels and %0d flush ticks, %0d blurred results checked",
			pixels_sent, flushes_sent, results_seen);
		$display("small frames incl. zero-sized registers, stray and partial flushes, stalls and a long hold-off");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
